// File: rtl/core/mcr_pkg.sv
// Shared constants, types and widths for the methylation call resimulator.
package mcr_pkg;

	localparam int FIELDS_PER_LINE_DEF = 15;
	localparam int QUEUE_DEPTH         = 2;

	localparam int BYTE_W   = 8;
	localparam int THRESH_W = 17;
	localparam int LCG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED           = 2'd1;

	localparam logic [LCG_W-1:0] SEED_RESET = 16'd1;
	localparam int LCG_MUL = 2053;
	localparam int LCG_ADD = 13849;

	localparam int METH_FIELD_A = 7;
	localparam int METH_FIELD_B = 10;

	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
	localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
	localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_U     = 8'h55;
	localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              call;
		logic              meth;
	} mcr_entry_t;

endpackage

// File: rtl/core/mcr_if.sv
// Stream and configuration interfaces of the methylation call resimulator.
interface mcr_in_if
	import mcr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface mcr_out_if
	import mcr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink   (input valid, input out_byte, output ready);
endinterface

interface mcr_cfg_if
	import mcr_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mcr_front.sv
// Front end: header and field tracking, generator and line classification.
module mcr_front
	import mcr_pkg::*;
#(
	parameter int FIELDS_PER_LINE = FIELDS_PER_LINE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	mcr_in_if.sink         in_ch,
	mcr_cfg_if.sink        cfg,
	input  logic           q_full,
	output logic           q_push,
	output mcr_entry_t     q_entry
);

	localparam int FW = $clog2(FIELDS_PER_LINE + 1);

	logic                header_done_q;
	logic [FW-1:0]       field_q;
	logic [LCG_W-1:0]    lcg_q;
	logic                meth_q;
	logic [THRESH_W-1:0] rate_q;

	logic             accept;
	logic             is_delim;
	logic             past_last;
	logic             call_field;
	logic [LCG_W-1:0] lcg_next;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;

	assign is_delim   = (in_ch.in_byte == CH_SPACE) || (in_ch.in_byte == CH_TAB)
		|| (in_ch.in_byte == CH_LF);
	assign past_last  = field_q >= FW'(FIELDS_PER_LINE);
	assign call_field = (field_q == FW'(METH_FIELD_A)) || (field_q == FW'(METH_FIELD_B));
	assign lcg_next   = LCG_W'(32'(lcg_q) * 32'(LCG_MUL) + 32'(LCG_ADD));

	assign q_push        = accept && (!header_done_q || !past_last);
	assign q_entry.data  = in_ch.in_byte;
	assign q_entry.call  = header_done_q && call_field;
	assign q_entry.meth  = meth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_done_q <= 1'b0;
			field_q       <= '0;
			lcg_q         <= SEED_RESET;
			meth_q        <= 1'b0;
			rate_q        <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_RATE_THRESHOLD: rate_q <= cfg.data;
					REG_SEED:           lcg_q  <= cfg.data[LCG_W-1:0];
					default:            ;
				endcase
			end
			if (accept) begin
				priority if (!header_done_q) begin
					if (in_ch.in_byte == CH_LF) header_done_q <= 1'b1;
				end else if (past_last) begin
					if (in_ch.in_byte == CH_LF) field_q <= '0;
				end else if (is_delim) begin
					if (in_ch.in_byte == CH_LF) begin
						field_q <= '0;
					end else begin
						if (field_q == FW'(METH_FIELD_A - 1)) begin
							lcg_q  <= lcg_next;
							meth_q <= {1'b0, lcg_next} < rate_q;
						end
						field_q <= field_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/mcr_queue.sv
// Short queue between front and back ends.
module mcr_queue
	import mcr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mcr_entry_t push_entry,
	input  logic       pop,
	output logic       full,
	output logic       empty,
	output mcr_entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mcr_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/mcr_back.sv
// Back end: call filtering, case rewrite and output register.
module mcr_back
	import mcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  mcr_entry_t q_head,
	output logic       q_pop,
	mcr_out_if.source  out_ch
);

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [BYTE_W-1:0] up;
	logic [BYTE_W-1:0] res;
	logic              keep;
	logic              load;

	assign load  = !out_valid_q || out_ch.ready;
	assign q_pop = !q_empty && load;

	always_comb begin
		up   = ((q_head.data >= CH_LO_A) && (q_head.data <= CH_LO_Z))
			? (q_head.data - CASE_BIT) : q_head.data;
		res  = q_head.data;
		keep = 1'b1;
		if (q_head.call) begin
			priority if ((q_head.data == CH_DOT) || (q_head.data == CH_TAB)) begin
				res = q_head.data;
			end else if ((up == CH_H) || (up == CH_X) || (up == CH_Z) || (up == CH_U)) begin
				res = q_head.meth ? up : (up + CASE_BIT);
			end else begin
				keep = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_pop && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && keep) out_byte_q <= res;
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;

endmodule

// File: rtl/core/methylation_call_resimulator_unit.sv
// Top level of the methylation call resimulator.
// An accepted byte passes through the queue and then the output register before it shows on the output.
// Throughput: one byte per cycle while the output is not held back, held by a two-entry queue and an output register.
// Input stalls only when the queue is full because the output is held back.
// Reset (arst_n low) clears header, field, flags and queue; generator loads seed 1.
// Configuration writes are always ready and take effect at once.
module methylation_call_resimulator_unit
	import mcr_pkg::*;
#(
	parameter int FIELDS_PER_LINE = FIELDS_PER_LINE_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	mcr_in_if.sink  in_ch,
	mcr_out_if.source out_ch,
	mcr_cfg_if.sink cfg
);

	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;
	mcr_entry_t q_entry;
	mcr_entry_t q_head;

	mcr_front #(
		.FIELDS_PER_LINE(FIELDS_PER_LINE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	mcr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (q_head)
	);

	mcr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// File: rtl/core/mcr_checker.sv
// Port-level assertions for the methylation call resimulator, bound to the top level.
module mcr_checker
	import mcr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte))
		else $error("output byte changed while stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) && !$past(in_acc, 4)
		&& $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
		&& $past(out_ready, 4) |-> !out_valid)
		else $error("output valid without a pending transaction");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind methylation_call_resimulator_unit mcr_checker u_mcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte)
);
